[sv/oaa_pkg.sv]
// ----------------------------------------------------------------------------
// Orbit and aim angle package
// Shared widths, the arctangent table, the CORDIC gain constant and the
// sideband type that travels with each request through the pipelines.
// ----------------------------------------------------------------------------
package oaa_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int GUARD         = 8;
  localparam int COORD_W       = 24;
  localparam int XW            = 37;
  localparam int ZW            = 32;
  localparam int MUL_LO        = 17;
  localparam int OFF_W         = 64 - 30 - GUARD;
  localparam int ANG_W         = 17;

  localparam logic signed [ZW-1:0] DEG90 = 32'sd5898240;

  localparam logic signed [ZW-1:0] ATAN_DEG16 [MAX_STAGES] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
    32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
    32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  typedef enum logic [1:0] {
    QUAD_NONE,
    QUAD_POS,
    QUAD_NEG
  } quad_e;

  typedef struct packed {
    logic                      zero;
    logic                      flip;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    logic signed [COORD_W-1:0] d;
  } side_t;

  // X result of the stage loop run on a unit vector of 2^30.
  function automatic longint gain_x();
    longint x;
    longint y;
    longint xs;
    longint ys;
    int     i;
    x = 64'sd1 <<< 30;
    y = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
      end else begin
        x = x - ys;
        y = y + xs;
      end
    end
    if (x <= 0) begin
      x = 1;
    end
    return x;
  endfunction

  localparam longint KX   = gain_x();
  localparam longint INVK = (64'sd1 <<< 60) / KX;
  localparam logic signed [30:0] INVK_C = 31'(INVK);

endpackage

[sv/orbit_and_aim_angle.sv]
// ----------------------------------------------------------------------------
// Orbit and aim angle
// Places an orbit point at a set radius from a centre towards an aim point
// and gives the facing angle from the orbit point to the aim point.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   in_valid_i / in_ready_o   target_present, centre_x/y, aim_x/y
//  result    out_valid_o / out_ready_i orbit_x/y, facing_angle, flipped
//  config    psel/penable/pwrite       orbit_radius at byte address 0
//
//  One request enters per cycle while in_ready_o is high; each result passes
//  through the two CORDIC pipelines and the gain multiply.
//  A request without a target passes through without a result.
//  When a result waits at the output, the whole pipeline holds its contents.
//  Reset clears the valid bits and the radius register.
module orbit_and_aim_angle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        target_present_i,
  input  logic signed [23:0]          centre_x_i,
  input  logic signed [23:0]          centre_y_i,
  input  logic signed [23:0]          aim_x_i,
  input  logic signed [23:0]          aim_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [23:0]          orbit_x_o,
  output logic signed [23:0]          orbit_y_o,
  output logic signed [16:0]          facing_angle_o,
  output logic                        flipped_o
);

  localparam int XW    = oaa_pkg::XW;
  localparam int ZW    = oaa_pkg::ZW;
  localparam int CW    = oaa_pkg::COORD_W;
  localparam int HW    = XW - oaa_pkg::MUL_LO;
  localparam int OFF_W = oaa_pkg::OFF_W;
  localparam int SH    = 30 + oaa_pkg::GUARD;
  localparam longint RND = 64'sd1 <<< (SH - 1);
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [ZW-10:0] ANG_MIN = -23'sd11520;
  localparam logic signed [ZW-10:0] ANG_MAX = 23'sd46080;

  logic        en;
  logic [22:0] radius_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {9'd0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      radius_q <= pwdata[22:0];
    end
  end

  logic out_vld_q;
  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  // First CORDIC: direction from centre to aim.
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic signed [XW-1:0] c1_x;
  logic signed [XW-1:0] c1_y;
  logic signed [XW-1:0] c1_u;
  oaa_pkg::side_t       c1_side;

  assign dx   = {aim_x_i[CW-1], aim_x_i} - {centre_x_i[CW-1], centre_x_i};
  assign dy   = {aim_y_i[CW-1], aim_y_i} - {centre_y_i[CW-1], centre_y_i};
  assign c1_x = {{(XW-CW-1-oaa_pkg::GUARD){dx[CW]}}, dx, {oaa_pkg::GUARD{1'b0}}};
  assign c1_y = {{(XW-CW-1-oaa_pkg::GUARD){dy[CW]}}, dy, {oaa_pkg::GUARD{1'b0}}};
  assign c1_u = {{(XW-23-oaa_pkg::GUARD){1'b0}}, radius_q, {oaa_pkg::GUARD{1'b0}}};

  always_comb begin
    c1_side      = '0;
    c1_side.zero = (dx == '0) && (dy == '0);
    c1_side.a    = centre_x_i;
    c1_side.b    = centre_y_i;
    c1_side.c    = aim_x_i;
    c1_side.d    = aim_y_i;
  end

  logic                 c1_vld;
  logic signed [ZW-1:0] c1_z;
  logic signed [XW-1:0] c1_uo;
  logic signed [XW-1:0] c1_vo;
  oaa_pkg::side_t       c1_so;

  oaa_cordic u_cordic_orbit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i & target_present_i),
    .x_i    (c1_x),
    .y_i    (c1_y),
    .u_i    (c1_u),
    .side_i (c1_side),
    .vld_o  (c1_vld),
    .z_o    (c1_z),
    .u_o    (c1_uo),
    .v_o    (c1_vo),
    .side_o (c1_so)
  );

  // Gain correction, split into two partial products per component.
  logic                   m1_vld_q;
  oaa_pkg::side_t         m1_side_q;
  logic signed [HW+30:0]  m1_uh_q;
  logic signed [HW+30:0]  m1_vh_q;
  logic signed [48:0]     m1_ul_q;
  logic signed [48:0]     m1_vl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= c1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q <= c1_so;
      m1_uh_q   <= $signed(c1_uo[XW-1:oaa_pkg::MUL_LO]) * oaa_pkg::INVK_C;
      m1_vh_q   <= $signed(c1_vo[XW-1:oaa_pkg::MUL_LO]) * oaa_pkg::INVK_C;
      m1_ul_q   <= $signed({1'b0, c1_uo[oaa_pkg::MUL_LO-1:0]}) * oaa_pkg::INVK_C;
      m1_vl_q   <= $signed({1'b0, c1_vo[oaa_pkg::MUL_LO-1:0]}) * oaa_pkg::INVK_C;
    end
  end

  logic signed [63:0]      pu;
  logic signed [63:0]      pv;
  logic                    m2_vld_q;
  oaa_pkg::side_t          m2_side_q;
  logic signed [OFF_W-1:0] m2_offx_q;
  logic signed [OFF_W-1:0] m2_offy_q;

  assign pu = (64'(m1_uh_q) <<< oaa_pkg::MUL_LO) + 64'(m1_ul_q) + RND;
  assign pv = (64'(m1_vh_q) <<< oaa_pkg::MUL_LO) + 64'(m1_vl_q) + RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_side_q <= m1_side_q;
      m2_offx_q <= m1_side_q.zero ? $signed({{(OFF_W-23){1'b0}}, radius_q}) : pu[63:SH];
      m2_offy_q <= m1_side_q.zero ? '0 : pv[63:SH];
    end
  end

  // Orbit point with saturation.
  logic signed [OFF_W:0] sx;
  logic signed [OFF_W:0] sy;
  logic                  m3_vld_q;
  logic signed [CW-1:0]  m3_ox_q;
  logic signed [CW-1:0]  m3_oy_q;
  logic signed [CW-1:0]  m3_ax_q;
  logic signed [CW-1:0]  m3_ay_q;

  assign sx = {{(OFF_W+1-CW){m2_side_q.a[CW-1]}}, m2_side_q.a}
            + {m2_offx_q[OFF_W-1], m2_offx_q};
  assign sy = {{(OFF_W+1-CW){m2_side_q.b[CW-1]}}, m2_side_q.b}
            + {m2_offy_q[OFF_W-1], m2_offy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else if (en) begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sx < (OFF_W+1)'(C_MIN)) begin
        m3_ox_q <= C_MIN;
      end else if (sx > (OFF_W+1)'(C_MAX)) begin
        m3_ox_q <= C_MAX;
      end else begin
        m3_ox_q <= sx[CW-1:0];
      end
      if (sy < (OFF_W+1)'(C_MIN)) begin
        m3_oy_q <= C_MIN;
      end else if (sy > (OFF_W+1)'(C_MAX)) begin
        m3_oy_q <= C_MAX;
      end else begin
        m3_oy_q <= sy[CW-1:0];
      end
      m3_ax_q <= m2_side_q.c;
      m3_ay_q <= m2_side_q.d;
    end
  end

  // Second CORDIC: angle from the orbit point to the aim point.
  logic signed [CW:0]   ex;
  logic signed [CW:0]   ey;
  logic signed [XW-1:0] c2_x;
  logic signed [XW-1:0] c2_y;
  oaa_pkg::side_t       c2_side;

  assign ex   = {m3_ax_q[CW-1], m3_ax_q} - {m3_ox_q[CW-1], m3_ox_q};
  assign ey   = {m3_ay_q[CW-1], m3_ay_q} - {m3_oy_q[CW-1], m3_oy_q};
  assign c2_x = {{(XW-CW-1-oaa_pkg::GUARD){ex[CW]}}, ex, {oaa_pkg::GUARD{1'b0}}};
  assign c2_y = {{(XW-CW-1-oaa_pkg::GUARD){ey[CW]}}, ey, {oaa_pkg::GUARD{1'b0}}};

  always_comb begin
    c2_side      = '0;
    c2_side.zero = (ex == '0) && (ey == '0);
    c2_side.flip = ex[CW];
    c2_side.a    = m3_ox_q;
    c2_side.b    = m3_oy_q;
  end

  logic                 c2_vld;
  logic signed [ZW-1:0] c2_z;
  logic signed [XW-1:0] c2_uo;
  logic signed [XW-1:0] c2_vo;
  oaa_pkg::side_t       c2_so;

  oaa_cordic u_cordic_aim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m3_vld_q),
    .x_i    (c2_x),
    .y_i    (c2_y),
    .u_i    ('0),
    .side_i (c2_side),
    .vld_o  (c2_vld),
    .z_o    (c2_z),
    .u_o    (c2_uo),
    .v_o    (c2_vo),
    .side_o (c2_so)
  );

  // Flip correction, rounding to degrees times 128 and clamping.
  logic signed [ZW-1:0]  zf;
  logic signed [ZW-1:0]  zr;
  logic signed [ZW-10:0] ang;
  logic signed [16:0]    ang_d;
  logic signed [23:0]    ox_q;
  logic signed [23:0]    oy_q;
  logic signed [16:0]    ang_q;
  logic                  flip_q;

  assign zf  = (c2_so.zero ? '0 : c2_z) + (c2_so.flip ? (oaa_pkg::DEG90 <<< 1) : '0);
  assign zr  = zf + 32'sd256;
  assign ang = zr[ZW-1:9];

  always_comb begin
    if (ang < ANG_MIN) begin
      ang_d = 17'(ANG_MIN);
    end else if (ang > ANG_MAX) begin
      ang_d = 17'(ANG_MAX);
    end else begin
      ang_d = ang[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q   <= c2_so.a;
      oy_q   <= c2_so.b;
      ang_q  <= ang_d;
      flip_q <= c2_so.flip;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign orbit_x_o      = ox_q;
  assign orbit_y_o      = oy_q;
  assign facing_angle_o = ang_q;
  assign flipped_o      = flip_q;

endmodule

[sv/oaa_cordic.sv]
// ----------------------------------------------------------------------------
// Orbit and aim angle CORDIC pipeline
// Vectoring pipeline with a quarter-turn pre-rotation, one register stage per
// iteration. A second vector is rotated alongside by the same decisions.
// ----------------------------------------------------------------------------
module oaa_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [oaa_pkg::XW-1:0] x_i,
  input  logic signed [oaa_pkg::XW-1:0] y_i,
  input  logic signed [oaa_pkg::XW-1:0] u_i,
  input  oaa_pkg::side_t                side_i,
  output logic                          vld_o,
  output logic signed [oaa_pkg::ZW-1:0] z_o,
  output logic signed [oaa_pkg::XW-1:0] u_o,
  output logic signed [oaa_pkg::XW-1:0] v_o,
  output oaa_pkg::side_t                side_o
);

  localparam int N = oaa_pkg::CORDIC_STAGES;

  logic                          vld_q  [N+1];
  logic signed [oaa_pkg::XW-1:0] x_q    [N+1];
  logic signed [oaa_pkg::XW-1:0] y_q    [N+1];
  logic signed [oaa_pkg::ZW-1:0] z_q    [N+1];
  logic signed [oaa_pkg::XW-1:0] u_q    [N+1];
  logic signed [oaa_pkg::XW-1:0] v_q    [N+1];
  oaa_pkg::quad_e                quad_q [N+1];
  oaa_pkg::side_t                side_q [N+1];

  logic signed [oaa_pkg::XW-1:0] x0_d;
  logic signed [oaa_pkg::XW-1:0] y0_d;
  logic signed [oaa_pkg::ZW-1:0] z0_d;
  oaa_pkg::quad_e                quad0_d;

  always_comb begin
    x0_d    = x_i;
    y0_d    = y_i;
    z0_d    = '0;
    quad0_d = oaa_pkg::QUAD_NONE;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d    = y_i;
        y0_d    = -x_i;
        z0_d    = oaa_pkg::DEG90;
        quad0_d = oaa_pkg::QUAD_POS;
      end else begin
        x0_d    = -y_i;
        y0_d    = x_i;
        z0_d    = -oaa_pkg::DEG90;
        quad0_d = oaa_pkg::QUAD_NEG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      u_q[0]    <= u_i;
      v_q[0]    <= '0;
      quad_q[0] <= quad0_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [oaa_pkg::ZW-1:0] AT = oaa_pkg::ATAN_DEG16[i];
    logic                          dir;
    logic signed [oaa_pkg::XW-1:0] xs;
    logic signed [oaa_pkg::XW-1:0] ys;
    logic signed [oaa_pkg::XW-1:0] us;
    logic signed [oaa_pkg::XW-1:0] vs;

    assign dir = ~y_q[i][oaa_pkg::XW-1];
    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign us  = u_q[i] >>> i;
    assign vs  = v_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= dir ? x_q[i] + ys : x_q[i] - ys;
        y_q[i+1]    <= dir ? y_q[i] - xs : y_q[i] + xs;
        z_q[i+1]    <= dir ? z_q[i] + AT : z_q[i] - AT;
        u_q[i+1]    <= dir ? u_q[i] - vs : u_q[i] + vs;
        v_q[i+1]    <= dir ? v_q[i] + us : v_q[i] - us;
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    case (quad_q[N])
      oaa_pkg::QUAD_POS: begin
        u_o = -v_q[N];
        v_o = u_q[N];
      end
      oaa_pkg::QUAD_NEG: begin
        u_o = v_q[N];
        v_o = -u_q[N];
      end
      default: begin
        u_o = u_q[N];
        v_o = v_q[N];
      end
    endcase
  end

  assign vld_o  = vld_q[N];
  assign z_o    = z_q[N];
  assign side_o = side_q[N];

endmodule
